// ===== sv/wsd_pkg.sv =====
// shared constants, codes and types for the work-stealing task deque
package wsd_pkg;

   localparam int DEPTH      = 4096;
   localparam int TASK_WIDTH = 64;

   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W    = $clog2(2 * DEPTH);
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int TASK_W   = 64;
   localparam int OCC_W    = 13;

   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(2 * DEPTH - 1);
   localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(DEPTH);

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEAL = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RESP = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_full;
      logic is_empty;
   } dp_status_type;

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
      return (p == POS_LAST) ? '0 : p + POS_W'(1);
   endfunction

   function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
      return (p == '0) ? POS_LAST : p - POS_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_of(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] s;
      s = (p >= POS_DEPTH) ? p - POS_DEPTH : p;
      return s[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/wsd_ctrl.sv =====
// handshake controller: accepts one item, then holds its result until taken
module wsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  wsd_pkg::dp_status_type dp_status,
   output wsd_pkg::dp_cmd_type    dp_cmd
);
   import wsd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall   = reset || (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign dp_cmd.load = !reset && (state_ff == S_IDLE) && req_valid;

   ast_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   ast_full_empty_excl: assert property (@(posedge clock) disable iff (reset)
      !(dp_status.is_full && dp_status.is_empty))
      else $error("deque full and empty at once");

   ast_load_then_resp: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |=> rsp_valid)
      else $error("accepted item gave no result");

endmodule

// ===== sv/wsd_dp.sv =====
// datapath: top and bottom positions, task store and result registers
module wsd_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  wsd_pkg::dp_cmd_type            dp_cmd,
   output wsd_pkg::dp_status_type         dp_status,
   input  logic [wsd_pkg::OP_W-1:0]       req_op,
   input  logic [wsd_pkg::TASK_W-1:0]     req_task_in,
   output logic [wsd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [wsd_pkg::TASK_W-1:0]     rsp_task_out,
   output logic [wsd_pkg::OCC_W-1:0]      rsp_occupancy
);
   import wsd_pkg::*;

   logic [POS_W-1:0]      top_ff, top_in;
   logic [POS_W-1:0]      bottom_ff, bottom_in;
   logic [TASK_WIDTH-1:0] store [DEPTH];
   logic [TASK_WIDTH-1:0] rd_data_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  task_sel_ff, task_sel_in;
   logic [OCC_W-1:0]      occ_ff;

   logic [POS_W-1:0]  held;
   logic [POS_W-1:0]  held_in;
   logic [ADDR_W-1:0] addr;
   logic              wr_en;
   logic              rd_en;
   logic              full;
   logic              empty;

   assign held  = (bottom_ff >= top_ff) ? bottom_ff - top_ff
                                        : bottom_ff + (POS_LAST - top_ff) + POS_W'(1);
   assign full  = (held == POS_DEPTH);
   assign empty = (held == '0);

   always_comb begin
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      status_in   = STATUS_OK;
      task_sel_in = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      addr        = slot_of(top_ff);
      unique case (req_op)
         OP_PUSH: begin
            addr = slot_of(bottom_ff);
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en     = dp_cmd.load;
               bottom_in = pos_inc(bottom_ff);
            end
         end
         OP_TAKE: begin
            addr = slot_of(pos_dec(bottom_ff));
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en       = dp_cmd.load;
               task_sel_in = 1'b1;
               bottom_in   = pos_dec(bottom_ff);
            end
         end
         OP_STEAL: begin
            addr = slot_of(top_ff);
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en       = dp_cmd.load;
               task_sel_in = 1'b1;
               top_in      = pos_inc(top_ff);
            end
         end
         OP_NONE: begin
            status_in = STATUS_OK;
         end
         default: status_in = STATUS_OK;
      endcase
   end

   assign held_in = (bottom_in >= top_in) ? bottom_in - top_in
                                          : bottom_in + (POS_LAST - top_in) + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         bottom_ff <= '0;
      end else if (dp_cmd.load) begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store[addr] <= req_task_in[TASK_WIDTH-1:0];
      if (rd_en) rd_data_ff <= store[addr];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         status_ff   <= status_in;
         task_sel_ff <= task_sel_in;
         occ_ff      <= OCC_W'(held_in);
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_task_out  = task_sel_ff ? TASK_W'(rd_data_ff) : '0;
   assign rsp_occupancy = occ_ff;

   assign dp_status.is_full  = full;
   assign dp_status.is_empty = empty;

   ast_held_bound: assert property (@(posedge clock) disable iff (reset)
      held <= POS_DEPTH)
      else $error("deque holds more than its capacity");

   ast_push_full: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && req_op == OP_PUSH && full |=> status_ff == STATUS_FULL)
      else $error("push on full deque not reported full");

   ast_take_shrinks: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && req_op == OP_TAKE && !empty |=> held == $past(held) - POS_W'(1))
      else $error("take did not remove one item");

endmodule

// ===== sv/work_stealing_task_deque.sv =====
// Work-stealing task deque top level. A bounded ring of wsd_pkg::DEPTH task
// handles: op push writes at the bottom (status full when at capacity), op take
// pops the newest handle from the bottom, op steal pops the oldest from the top
// (status empty when nothing is held), and op 3 only reports the occupancy.
// An item is accepted in the cycle in which the single store port is written or
// read, and its result is offered from the next cycle until taken; the next item
// is accepted in the cycle after the result is taken.
// The task store needs no clearing after reset, so items are accepted at once.
module work_stealing_task_deque (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [wsd_pkg::OP_W-1:0]     req_op,
   input  logic [wsd_pkg::TASK_W-1:0]   req_task_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [wsd_pkg::STATUS_W-1:0] rsp_status,
   output logic [wsd_pkg::TASK_W-1:0]   rsp_task_out,
   output logic [wsd_pkg::OCC_W-1:0]    rsp_occupancy
);
   import wsd_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   wsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   wsd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .req_op        (req_op),
      .req_task_in   (req_task_in),
      .rsp_status    (rsp_status),
      .rsp_task_out  (rsp_task_out),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule
